// ===== design/xxh_pkg.sv =====
// ----------------------------------------------------------------------------
// xxh_pkg
// Shared constants, the command format between front and back, and helpers
// for the 32-bit xxHash core.
// ----------------------------------------------------------------------------
package xxh_pkg;

	localparam logic [31:0] PRIME1 = 32'd2654435761;
	localparam logic [31:0] PRIME2 = 32'd2246822519;
	localparam logic [31:0] PRIME3 = 32'd3266489917;
	localparam logic [31:0] PRIME4 = 32'd668265263;
	localparam logic [31:0] PRIME5 = 32'd374761393;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	// one command from the front to the back
	typedef struct packed {
		logic        word_vld;  // a whole word of the current stripe is carried
		logic [1:0]  widx;      // word position in the stripe
		logic [31:0] word;      // little-endian word
		logic        fin;       // message ends after this command
		logic [1:0]  nwords;    // whole words left in an open stripe
		logic [1:0]  nbytes;    // bytes left after those words
		logic [23:0] tail;      // those bytes, first byte lowest
		logic        long_msg;  // at least one full stripe seen
		logic [31:0] len;       // message length mod 2^32
	} cmd_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic logic [31:0] lane_seed(input logic [31:0] seed, input logic [1:0] idx);
		logic [31:0] v;
		unique case (idx)
			2'd0:    v = seed + PRIME1 + PRIME2;
			2'd1:    v = seed + PRIME2;
			2'd2:    v = seed;
			default: v = seed - PRIME1;
		endcase
		return v;
	endfunction

endpackage

// ===== design/xxh_front.sv =====
// ----------------------------------------------------------------------------
// xxh_front
// Takes one byte per beat, packs bytes into words, counts the message length
// and stripe position, and issues commands to the back end.
// ----------------------------------------------------------------------------
module xxh_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [7:0]    data_byte,
	input  logic          has_byte,
	input  logic          last,
	input  logic          cfg_we,
	input  logic          q_full,
	output logic          cmd_push,
	output xxh_pkg::cmd_t cmd
);

	logic [3:0]  fill_q;
	logic [31:0] len_q;
	logic        long_q;
	logic [23:0] acc_q;

	logic        accept;
	logic [1:0]  bp;
	logic [23:0] acc_n;
	logic [3:0]  fill_n;
	logic        long_n;
	logic [31:0] len_n;
	logic        word_done;

	assign full   = q_full;
	assign accept = push & ~q_full;
	assign bp     = fill_q[1:0];

	always_comb begin
		acc_n = acc_q;
		if (has_byte) begin
			case (bp)
				2'd0:    acc_n[7:0]   = data_byte;
				2'd1:    acc_n[15:8]  = data_byte;
				2'd2:    acc_n[23:16] = data_byte;
				default: acc_n        = acc_q;
			endcase
		end
	end

	assign fill_n    = has_byte ? fill_q + 4'd1 : fill_q;
	assign long_n    = long_q | (has_byte & (fill_q == 4'd15));
	assign len_n     = len_q + {31'd0, has_byte};
	assign word_done = has_byte & (bp == 2'd3);

	always_comb begin
		cmd.word_vld = word_done;
		cmd.widx     = fill_q[3:2];
		cmd.word     = {data_byte, acc_q};
		cmd.fin      = last;
		cmd.nwords   = fill_n[3:2];
		cmd.nbytes   = fill_n[1:0];
		cmd.tail     = acc_n;
		cmd.long_msg = long_n;
		cmd.len      = len_n;
	end

	assign cmd_push = accept & (word_done | last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
			long_q <= 1'b0;
		end else if (cfg_we || (accept && last)) begin
			fill_q <= '0;
			len_q  <= '0;
			long_q <= 1'b0;
		end else if (accept) begin
			fill_q <= fill_n;
			len_q  <= len_n;
			long_q <= long_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q <= acc_n;
		end
	end

endmodule

// ===== design/xxh_cmdq.sv =====
// ----------------------------------------------------------------------------
// xxh_cmdq
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module xxh_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  xxh_pkg::cmd_t din,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output xxh_pkg::cmd_t dout
);

	xxh_pkg::cmd_t                mem_q [xxh_pkg::QDEPTH];
	logic [xxh_pkg::QPTR_W-1:0]   wr_q;
	logic [xxh_pkg::QPTR_W-1:0]   rd_q;
	logic [xxh_pkg::QPTR_W:0]     cnt_q;
	logic                         do_push;
	logic                         do_pop;

	assign full    = cnt_q == (xxh_pkg::QPTR_W + 1)'(xxh_pkg::QDEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (xxh_pkg::QPTR_W + 1)'(xxh_pkg::QDEPTH))
		else $error("command queue count out of range");
`endif

endmodule

// ===== design/xxh_back.sv =====
// ----------------------------------------------------------------------------
// xxh_back
// Sequencer around one shared 32x32 multiplier: runs the lane rounds of
// each stripe, then the tail folds and avalanche of a message, and holds
// the finished hash until it is taken.
// ----------------------------------------------------------------------------
module xxh_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_wdata,
	input  logic          q_empty,
	input  xxh_pkg::cmd_t q_dout,
	output logic          q_pop,
	input  logic          pop,
	output logic          empty,
	output logic [31:0]   hash
);

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_LANE_A   = 11'b000_0000_0010,
		S_LANE_B   = 11'b000_0000_0100,
		S_LANE_C   = 11'b000_0000_1000,
		S_FIN_BASE = 11'b000_0001_0000,
		S_TAIL_A   = 11'b000_0010_0000,
		S_TAIL_B   = 11'b000_0100_0000,
		S_TAIL_C   = 11'b000_1000_0000,
		S_AVAL_A   = 11'b001_0000_0000,
		S_AVAL_B   = 11'b010_0000_0000,
		S_AVAL_C   = 11'b100_0000_0000
	} state_t;

	state_t      state_q, state_n;
	logic [31:0] seed_q;
	logic [31:0] lane_q [4];
	logic [31:0] w_q [4];
	logic [31:0] p_q;
	logic [31:0] h_q;
	logic [1:0]  k_q;
	logic [1:0]  wi_q;
	logic [1:0]  bi_q;
	logic        word_mode_q;
	logic        fin_q;
	logic [1:0]  nw_q;
	logic [1:0]  nb_q;
	logic [23:0] tb_q;
	logic        long_q;
	logic [31:0] len_q;
	logic [31:0] out_q;
	logic        out_vld_q;

	logic [1:0]  widx_sel;
	logic [31:0] w_sel;
	logic [31:0] lane_sel;
	logic [31:0] sum;
	logic [7:0]  tail_byte;
	logic [31:0] base;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic        mul_en;
	logic        out_wr;
	logic        tail_word;
	logic        tail_more;

	assign widx_sel  = (state_q == S_LANE_A) ? k_q : wi_q;
	assign w_sel     = w_q[widx_sel];
	assign lane_sel  = lane_q[k_q];
	assign sum       = ((state_q == S_LANE_B) ? lane_sel : h_q) + p_q;
	assign tail_word = wi_q != nw_q;
	assign tail_more = tail_word | (bi_q != nb_q);

	always_comb begin
		case (bi_q)
			2'd0:    tail_byte = tb_q[7:0];
			2'd1:    tail_byte = tb_q[15:8];
			default: tail_byte = tb_q[23:16];
		endcase
	end

	// lane merge for long messages, seed path for short ones
	assign base = long_q
		? xxh_pkg::rotl32(lane_q[0], 1) + xxh_pkg::rotl32(lane_q[1], 7)
		  + xxh_pkg::rotl32(lane_q[2], 12) + xxh_pkg::rotl32(lane_q[3], 18)
		: seed_q + xxh_pkg::PRIME5;

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		unique case (state_q)
			S_LANE_A: begin
				mul_a = w_sel;
				mul_b = xxh_pkg::PRIME2;
			end
			S_LANE_B: begin
				mul_a = xxh_pkg::rotl32(sum, 13);
				mul_b = xxh_pkg::PRIME1;
			end
			S_TAIL_A: begin
				mul_a = tail_word ? w_sel : {24'd0, tail_byte};
				mul_b = tail_word ? xxh_pkg::PRIME3 : xxh_pkg::PRIME5;
			end
			S_TAIL_B: begin
				mul_a = word_mode_q ? xxh_pkg::rotl32(sum, 17) : xxh_pkg::rotl32(sum, 11);
				mul_b = word_mode_q ? xxh_pkg::PRIME4 : xxh_pkg::PRIME1;
			end
			S_AVAL_A: begin
				mul_a = h_q ^ (h_q >> 15);
				mul_b = xxh_pkg::PRIME2;
			end
			S_AVAL_B: begin
				mul_a = p_q ^ (p_q >> 13);
				mul_b = xxh_pkg::PRIME3;
			end
			default: mul_en = 1'b0;
		endcase
	end

	assign q_pop  = (state_q == S_IDLE) & ~q_empty;
	assign out_wr = (state_q == S_AVAL_C) & (~out_vld_q | pop);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					if (q_dout.word_vld && q_dout.widx == 2'd3) begin
						state_n = S_LANE_A;
					end else if (q_dout.fin) begin
						state_n = S_FIN_BASE;
					end
				end
			end
			S_LANE_A:   state_n = S_LANE_B;
			S_LANE_B:   state_n = S_LANE_C;
			S_LANE_C: begin
				if (k_q != 2'd3) begin
					state_n = S_LANE_A;
				end else begin
					state_n = fin_q ? S_FIN_BASE : S_IDLE;
				end
			end
			S_FIN_BASE: state_n = S_TAIL_A;
			S_TAIL_A:   state_n = tail_more ? S_TAIL_B : S_AVAL_A;
			S_TAIL_B:   state_n = S_TAIL_C;
			S_TAIL_C:   state_n = S_TAIL_A;
			S_AVAL_A:   state_n = S_AVAL_B;
			S_AVAL_B:   state_n = S_AVAL_C;
			S_AVAL_C:   state_n = out_wr ? S_IDLE : S_AVAL_C;
			default:    state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seed_q      <= '0;
			for (int i = 0; i < 4; i++) begin
				lane_q[i] <= xxh_pkg::lane_seed(32'd0, 2'(i));
			end
			k_q         <= '0;
			wi_q        <= '0;
			bi_q        <= '0;
			word_mode_q <= 1'b0;
			fin_q       <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			// lanes restart on a seed write and after each finished message
			if (cfg_we) begin
				for (int i = 0; i < 4; i++) begin
					lane_q[i] <= xxh_pkg::lane_seed(cfg_wdata, 2'(i));
				end
			end else if (out_wr) begin
				for (int i = 0; i < 4; i++) begin
					lane_q[i] <= xxh_pkg::lane_seed(seed_q, 2'(i));
				end
			end else if (state_q == S_LANE_C) begin
				lane_q[k_q] <= p_q;
			end
			if (q_pop) begin
				k_q   <= '0;
				fin_q <= q_dout.fin;
			end else if (state_q == S_LANE_C) begin
				k_q <= k_q + 2'd1;
			end
			if (state_q == S_FIN_BASE) begin
				wi_q <= '0;
				bi_q <= '0;
			end else if (state_q == S_TAIL_C) begin
				if (word_mode_q) begin
					wi_q <= wi_q + 2'd1;
				end else begin
					bi_q <= bi_q + 2'd1;
				end
			end
			if (state_q == S_TAIL_A) begin
				word_mode_q <= tail_word;
			end
			if (out_wr) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (q_dout.word_vld) begin
				w_q[q_dout.widx] <= q_dout.word;
			end
			nw_q   <= q_dout.nwords;
			nb_q   <= q_dout.nbytes;
			tb_q   <= q_dout.tail;
			long_q <= q_dout.long_msg;
			len_q  <= q_dout.len;
		end
		if (mul_en) begin
			p_q <= mul_a * mul_b;
		end
		if (state_q == S_FIN_BASE) begin
			h_q <= base + len_q;
		end else if (state_q == S_TAIL_C) begin
			h_q <= p_q;
		end
		if (out_wr) begin
			out_q <= p_q ^ (p_q >> 16);
		end
	end

	assign empty = ~out_vld_q;
	assign hash  = out_q;

`ifndef NO_ASSERTIONS
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AVAL_C && out_vld_q && !pop) |=> (state_q == S_AVAL_C && out_vld_q))
		else $error("waiting hash overwritten");
	a_tail_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TAIL_C) |-> (word_mode_q ? (wi_q != nw_q) : (bi_q != nb_q)))
		else $error("tail step without work left");
	a_stripe_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LANE_C && k_q == 2'd3 && !fin_q) |=> (state_q == S_IDLE))
		else $error("stripe end did not return to idle");
`endif

endmodule

// ===== design/xxh32_stream_hash_core.sv =====
// ----------------------------------------------------------------------------
// xxh32_stream_hash_core
// Streaming 32-bit xxHash of a byte message with a programmable seed.
// ----------------------------------------------------------------------------
// usage:
// - input side is a queue: drive data_byte, has_byte, last with push; a beat
//   is taken when push is high and full is low. has_byte low with last high
//   ends a message without adding a byte; has_byte and last both low is a no-op
// - result side is a queue: hash is valid while empty is low and is taken
//   when pop is high; one hash per message, in message order
// - cfg_we with cfg_wdata loads the seed and drops any message in progress;
//   write it only while nothing is in flight
// - the front takes one byte per cycle while full is low; every fourth byte
//   becomes a command for the back end, whose work per 16-byte stripe is four
//   queue pops and a lane round (S_LANE_A, S_LANE_B, S_LANE_C) per word, so
//   one byte per cycle holds inside a message; a message end runs S_FIN_BASE,
//   S_TAIL_A, a S_TAIL_B/C/A round per leftover word or byte and S_AVAL_A/B/C,
//   so short messages back to back fill the queue
// - after the last beat is accepted, empty goes low once the back end has run
//   any backlog, any lane rounds of a closing stripe, and the end states
// - when the receiver stalls, the finished hash is held, the back end waits
//   and the front keeps taking bytes until the 4-entry command queue fills
// - reset clears the seed to zero, the queue and the output; no clearing pass
// ----------------------------------------------------------------------------
module xxh32_stream_hash_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] hash,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	xxh_pkg::cmd_t cmd;
	xxh_pkg::cmd_t q_dout;
	logic          cmd_push;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;

	xxh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.has_byte  (has_byte),
		.last      (last),
		.cfg_we    (cfg_we),
		.q_full    (q_full),
		.cmd_push  (cmd_push),
		.cmd       (cmd)
	);

	xxh_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.dout   (q_dout)
	);

	xxh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_empty   (q_empty),
		.q_dout    (q_dout),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.hash      (hash)
	);

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming 32-bit xxHash core. Messages of
// random length and content are pushed one byte per beat under several
// seeds; a local model of the lanes and the finalization predicts every
// hash, and each popped hash is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

	localparam int SETTLE     = 80;
	localparam int STALL_LEN  = 400;
	localparam int WATCHDOG   = 4000;
	localparam int PHASE_BEATS = 100;

	typedef struct packed {
		logic [7:0] data_value;
		logic       has;
		logic       fin;
	} beat_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        push      = 1'b0;
	logic        full;
	logic [7:0]  data_byte = 8'd0;
	logic        has_byte  = 1'b0;
	logic        last      = 1'b0;
	logic        empty;
	logic        pop       = 1'b0;
	logic [31:0] hash;
	logic        cfg_we    = 1'b0;
	logic [31:0] cfg_wdata = 32'd0;

	beat_t       pending_beats[$];
	logic [31:0] expected_hashes[$];

	// model state
	logic [31:0] hash_seed;
	logic [31:0] lanes [4];
	logic [7:0]  stripe_bytes [16];
	int unsigned stripe_fill;
	logic [31:0] msg_len;
	logic        seen_stripe;

	int          fail_count = 0;
	int          beats_made = 0;
	int          quiet_cycles = 0;
	int          hold_left = 0;
	logic        stall_req = 1'b0;
	logic        stall_done = 1'b0;
	logic        calm = 1'b0;
	logic [31:0] want;

	xxh32_stream_hash_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.has_byte  (has_byte),
		.last      (last),
		.empty     (empty),
		.pop       (pop),
		.hash      (hash),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] rot_left(input logic [31:0] x, input int unsigned r);
		logic [63:0] both;
		both = {x, x} << r;
		return both[63:32];
	endfunction

	function automatic logic [31:0] stripe_word(input int unsigned p);
		return {stripe_bytes[p + 3], stripe_bytes[p + 2], stripe_bytes[p + 1], stripe_bytes[p]};
	endfunction

	function void restart_message();
		lanes[0] = hash_seed + xxh_pkg::PRIME1 + xxh_pkg::PRIME2;
		lanes[1] = hash_seed + xxh_pkg::PRIME2;
		lanes[2] = hash_seed;
		lanes[3] = hash_seed - xxh_pkg::PRIME1;
		stripe_fill = 0;
		msg_len = 32'd0;
		seen_stripe = 1'b0;
	endfunction

	function logic [31:0] message_digest();
		logic [31:0] h;
		int unsigned i;
		if (seen_stripe) begin
			h = rot_left(lanes[0], 1) + rot_left(lanes[1], 7)
			  + rot_left(lanes[2], 12) + rot_left(lanes[3], 18);
		end else begin
			h = hash_seed + xxh_pkg::PRIME5;
		end
		h = h + msg_len;
		i = 0;
		while (i + 4 <= stripe_fill) begin
			h = rot_left(h + stripe_word(i) * xxh_pkg::PRIME3, 17) * xxh_pkg::PRIME4;
			i = i + 4;
		end
		while (i < stripe_fill) begin
			h = rot_left(h + {24'd0, stripe_bytes[i]} * xxh_pkg::PRIME5, 11) * xxh_pkg::PRIME1;
			i = i + 1;
		end
		h = h ^ (h >> 15);
		h = h * xxh_pkg::PRIME2;
		h = h ^ (h >> 13);
		h = h * xxh_pkg::PRIME3;
		h = h ^ (h >> 16);
		return h;
	endfunction

	function void absorb_beat(input beat_t b);
		int k;
		if (b.has) begin
			stripe_bytes[stripe_fill] = b.data_value;
			stripe_fill = stripe_fill + 1;
			msg_len = msg_len + 32'd1;
			if (stripe_fill == 16) begin
				for (k = 0; k < 4; k++)
					lanes[k] = rot_left(lanes[k] + stripe_word(4 * k) * xxh_pkg::PRIME2, 13)
						* xxh_pkg::PRIME1;
				stripe_fill = 0;
				seen_stripe = 1'b1;
			end
		end
		if (b.fin) begin
			expected_hashes.push_back(message_digest());
			restart_message();
		end
	endfunction

	// input beats and hashes, both taken at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				absorb_beat(pending_beats[0]);
				void'(pending_beats.pop_front());
			end
			if (pop && !empty) begin
				if (expected_hashes.size() == 0) begin
					$error("hash: expected none, actual %h", hash);
					fail_count++;
				end else begin
					want = expected_hashes.pop_front();
					if (hash !== want) begin
						$error("hash: expected %h, actual %h", want, hash);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// sender
	always @(negedge clk) begin
		if (arst_n && pending_beats.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
			push      <= 1'b1;
			data_byte <= pending_beats[0].data_value;
			has_byte  <= pending_beats[0].has;
			last      <= pending_beats[0].fin;
		end else begin
			push <= 1'b0;
		end
	end

	// receiver, with a long hold-off on request
	always @(negedge clk) begin
		if (stall_req && !stall_done) begin
			hold_left = STALL_LEN;
			stall_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			pop <= 1'b0;
		end else begin
			pop <= calm || ($urandom_range(99) >= 13);
		end
	end

	task automatic add_beat(input logic [7:0] d, input logic has, input logic fin);
		beat_t b;
		b.data_value = d;
		b.has = has;
		b.fin = fin;
		pending_beats.push_back(b);
		if (has || fin)
			beats_made++;
	endtask

	// a message with optional empty beats mixed in; closed on the last byte or by
	// a separate empty last beat, or left open
	task automatic add_message(input int len, input bit close_on_byte, input bit closed);
		int k;
		for (k = 0; k < len; k++) begin
			if ($urandom_range(9) == 0)
				add_beat(8'($urandom), 1'b0, 1'b0);
			add_beat(8'($urandom), 1'b1, closed && close_on_byte && (k == len - 1));
		end
		if (closed && (!close_on_byte || len == 0))
			add_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic add_random_messages(input int target);
		int r;
		int len;
		target = beats_made + target;
		while (beats_made < target) begin
			r = $urandom_range(99);
			if (r < 70)
				len = $urandom_range(20, 0);
			else if (r < 95)
				len = $urandom_range(48, 21);
			else
				len = $urandom_range(80, 49);
			add_message(len, 1'($urandom_range(1)), 1'b1);
		end
	endtask

	task automatic wait_drained();
		while (pending_beats.size() > 0 || expected_hashes.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		hash_seed = value;
		restart_message();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int k;
		hash_seed = 32'd0;
		for (k = 0; k < 16; k++)
			stripe_bytes[k] = 8'd0;
		restart_message();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty message, no-op beats, single byte, short tail, one stripe
		add_beat(8'hFF, 1'b0, 1'b1);
		add_beat(8'h00, 1'b0, 1'b0);
		add_beat(8'hFF, 1'b0, 1'b0);
		add_beat(8'hFF, 1'b1, 1'b1);
		add_beat(8'h00, 1'b1, 1'b0);
		add_beat(8'h80, 1'b1, 1'b0);
		add_beat(8'h7F, 1'b1, 1'b0);
		add_beat(8'h55, 1'b0, 1'b1);
		for (k = 0; k < 16; k++)
			add_beat((k % 2) ? 8'hFF : 8'h00, 1'b1, k == 15);
		// open message, dropped by the seed write that follows
		add_message(3, 1'b1, 1'b0);
		wait_drained();

		write_seed(32'hFFFF_FFFF);
		add_random_messages(PHASE_BEATS);
		add_message(21, 1'b1, 1'b0);
		wait_drained();

		// receiver holds off while the sender keeps offering beats
		write_seed($urandom);
		@(posedge clk);
		stall_req = 1'b1;
		add_random_messages(PHASE_BEATS);
		wait_drained();

		// back to back with no idling on either side
		write_seed(32'h0000_0000);
		calm = 1'b1;
		add_random_messages(PHASE_BEATS);
		wait_drained();
		calm = 1'b0;

		write_seed($urandom);
		add_random_messages(PHASE_BEATS);
		wait_drained();

		write_seed(32'h8000_0001);
		add_random_messages(PHASE_BEATS);
		wait_drained();

		if (fail_count == 0 && expected_hashes.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
